[rtl/cau_pkg.sv]
// Shared types, constants and sign-magnitude helpers for the complex arithmetic unit.
// Used by every module in rtl/; depends on nothing else.
`timescale 1ns / 1ps

package cau_pkg;

	localparam int W   = 32;          // operand and result width
	localparam int F   = 16;          // fraction bits
	localparam int PW  = 2 * W;       // product width
	localparam int QW  = W + 2;       // quotient bits kept by the divider
	localparam int OVS = QW - F;      // dividend shift for the quotient overflow test

	localparam logic [PW-1:0] LIMIT = PW'(1) << (W - 1);
	localparam logic [PW-1:0] HALF  = (PW'(1) << F) >> 1;

	typedef enum logic [2:0] {
		CMD_ADD,
		CMD_SUB,
		CMD_MUL,
		CMD_DIV,
		CMD_CONJ,
		CMD_NEG,
		CMD_ABS2,
		CMD_ABS
	} cmd_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	typedef struct packed {
		logic          neg;
		logic [PW-1:0] mag;
	} sm_t;

	typedef struct packed {
		logic         sat;
		logic [W-1:0] val;
	} sat_t;

	typedef struct packed {
		cmd_t          cmd;
		sm_t           re;
		sm_t           im;
		logic [PW-1:0] den;
	} prep_t;

	typedef struct packed {
		cmd_t          cmd;
		sm_t           re;
		sm_t           im;
		logic [PW-1:0] den;
		logic          dz;
		logic          ovf_re;
		logic          ovf_im;
		logic [QW-1:0] q_re;
		logic [QW-1:0] q_im;
		logic [PW-1:0] r_re;
		logic [PW-1:0] r_im;
		logic [PW-1:0] sq_rem;
		logic [W-1:0]  sq_root;
	} iter_t;

	function automatic sm_t sm_add(sm_t a, sm_t b);
		sm_t v;
		if (a.neg == b.neg) begin
			v.neg = a.neg;
			v.mag = a.mag + b.mag;
		end else if (a.mag >= b.mag) begin
			v.neg = a.neg;
			v.mag = a.mag - b.mag;
		end else begin
			v.neg = b.neg;
			v.mag = b.mag - a.mag;
		end
		return v;
	endfunction

	function automatic logic [PW-1:0] rnd(logic [PW-1:0] m);
		logic [PW-1:0] t;
		t = m + HALF;
		return t >> F;
	endfunction

	function automatic sat_t sm_sat(sm_t a);
		sat_t v;
		v.sat = 1'b0;
		v.val = '0;
		if (a.mag == '0) begin
			v.val = '0;
		end else if (a.neg) begin
			if (a.mag > LIMIT) begin
				v.sat = 1'b1;
				v.val = LIMIT[W-1:0];
			end else begin
				v.val = ~a.mag[W-1:0] + 1'b1;
			end
		end else begin
			if (a.mag > LIMIT - 1'b1) begin
				v.sat = 1'b1;
				v.val = W'(LIMIT - 1'b1);
			end else begin
				v.val = a.mag[W-1:0];
			end
		end
		return v;
	endfunction

endpackage

[rtl/complex_arithmetic_unit_top.sv]
// Complex arithmetic unit top level: front end, divider/root pipeline, back end.
// Depends on cau_pkg, cau_prep, cau_iter and cau_post.
//
// Input channel: in_valid/in_stall with cmd, a_re, a_im, b_re, b_im (Q16.16).
// A transaction is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with res_re, res_im and status.
// Every command runs through the same 39 register stages: three for operand
// capture, products and combining adds, one divider setup stage, 34 divider
// steps (one quotient bit per stage; the square root shares these stages,
// one root bit in each of the first W of them), and the output register. One
// transaction is taken per cycle as long as the output side keeps up.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset (arst_n low) clears all valid bits; the pipeline comes up empty and
// accepts transactions as soon as reset is released.
`timescale 1ns / 1ps

module complex_arithmetic_unit_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   cmd,
	input  logic signed [cau_pkg::W-1:0] a_re,
	input  logic signed [cau_pkg::W-1:0] a_im,
	input  logic signed [cau_pkg::W-1:0] b_re,
	input  logic signed [cau_pkg::W-1:0] b_im,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [cau_pkg::W-1:0] res_re,
	output logic signed [cau_pkg::W-1:0] res_im,
	output logic [1:0]                   status
);
	import cau_pkg::*;

	logic  adv;
	logic  prep_vld, iter_vld;
	prep_t prep;
	iter_t iter;

	// advance everything unless a finished result is held
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	cau_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.cmd      (cmd),
		.a_re     (a_re),
		.a_im     (a_im),
		.b_re     (b_re),
		.b_im     (b_im),
		.vld_o    (prep_vld),
		.prep_o   (prep)
	);

	cau_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_i  (prep_vld),
		.prep_i (prep),
		.vld_o  (iter_vld),
		.iter_o (iter)
	);

	cau_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.vld_i     (iter_vld),
		.iter_i    (iter),
		.out_valid (out_valid),
		.res_re    (res_re),
		.res_im    (res_im),
		.status    (status)
	);

	a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	a_divz_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_DIVZ) |-> (res_re == '0 && res_im == '0))
		else $error("divide by zero result is not zero");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_SAT) |->
		(res_re == W'(LIMIT - 1'b1) || res_re == LIMIT[W-1:0] ||
		 res_im == W'(LIMIT - 1'b1) || res_im == LIMIT[W-1:0]))
		else $error("saturated status without a clamped part");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_DIVZ || status == ST_SAT))
		else $error("undefined status code");

endmodule

[rtl/cau_prep.sv]
// Front end: operand capture as sign-magnitude, the six products, and the combining adds.
// Three pipeline stages; depends on cau_pkg.
`timescale 1ns / 1ps

module cau_prep (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  logic [2:0]                  cmd,
	input  logic signed [cau_pkg::W-1:0] a_re,
	input  logic signed [cau_pkg::W-1:0] a_im,
	input  logic signed [cau_pkg::W-1:0] b_re,
	input  logic signed [cau_pkg::W-1:0] b_im,
	output logic                        vld_o,
	output cau_pkg::prep_t              prep_o
);
	import cau_pkg::*;

	// stage 1: sign-magnitude operands
	logic          vld_s1;
	cmd_t          cmd_s1;
	logic [3:0]    neg_s1;
	logic [W-1:0]  ar_s1, ai_s1, br_s1, bi_s1;

	// stage 2: products
	logic          vld_s2;
	cmd_t          cmd_s2;
	logic [3:0]    neg_s2;
	logic [W-1:0]  ar_s2, ai_s2, br_s2, bi_s2;
	logic [PW-1:0] prr_s2, pii_s2, pri_s2, pir_s2, sq0_s2, sq1_s2;

	// stage 3: combined numerators and denominator
	logic          vld_s3;
	prep_t         prep_s3;

	logic [W-1:0]  sqx, sqy;
	sm_t           xr, yr, xi, yi, zero_sm;
	sm_t           ar_sm, ai_sm, br_sm, bi_sm;
	sm_t           prr_sm, pii_sm, pri_sm, pir_sm;
	logic [PW-1:0] den;

	function automatic logic [W-1:0] mag_of(logic [W-1:0] x);
		return x[W-1] ? (~x + 1'b1) : x;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd_t'(cmd);
			neg_s1 <= {b_im[W-1], b_re[W-1], a_im[W-1], a_re[W-1]};
			ar_s1  <= mag_of(a_re);
			ai_s1  <= mag_of(a_im);
			br_s1  <= mag_of(b_re);
			bi_s1  <= mag_of(b_im);
		end
	end

	// squares use b for divide (denominator) and a otherwise (magnitude)
	always_comb begin
		sqx = (cmd_s1 == CMD_DIV) ? br_s1 : ar_s1;
		sqy = (cmd_s1 == CMD_DIV) ? bi_s1 : ai_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2 <= cmd_s1;
			neg_s2 <= neg_s1;
			ar_s2  <= ar_s1;
			ai_s2  <= ai_s1;
			br_s2  <= br_s1;
			bi_s2  <= bi_s1;
			prr_s2 <= ar_s1 * br_s1;
			pii_s2 <= ai_s1 * bi_s1;
			pri_s2 <= ar_s1 * bi_s1;
			pir_s2 <= ai_s1 * br_s1;
			sq0_s2 <= sqx * sqx;
			sq1_s2 <= sqy * sqy;
		end
	end

	always_comb begin
		zero_sm = '{neg: 1'b0, mag: '0};
		ar_sm   = '{neg: neg_s2[0], mag: PW'(ar_s2)};
		ai_sm   = '{neg: neg_s2[1], mag: PW'(ai_s2)};
		br_sm   = '{neg: neg_s2[2], mag: PW'(br_s2)};
		bi_sm   = '{neg: neg_s2[3], mag: PW'(bi_s2)};
		prr_sm  = '{neg: neg_s2[0] ^ neg_s2[2], mag: prr_s2};
		pii_sm  = '{neg: neg_s2[1] ^ neg_s2[3], mag: pii_s2};
		pri_sm  = '{neg: neg_s2[0] ^ neg_s2[3], mag: pri_s2};
		pir_sm  = '{neg: neg_s2[1] ^ neg_s2[2], mag: pir_s2};
		den     = sq0_s2 + sq1_s2;
		xr = zero_sm;
		yr = zero_sm;
		xi = zero_sm;
		yi = zero_sm;
		unique case (cmd_s2)
			CMD_ADD: begin
				xr = ar_sm; yr = br_sm;
				xi = ai_sm; yi = bi_sm;
			end
			CMD_SUB: begin
				xr = ar_sm; yr = '{neg: ~br_sm.neg, mag: br_sm.mag};
				xi = ai_sm; yi = '{neg: ~bi_sm.neg, mag: bi_sm.mag};
			end
			CMD_MUL: begin
				xr = prr_sm; yr = '{neg: ~pii_sm.neg, mag: pii_sm.mag};
				xi = pri_sm; yi = pir_sm;
			end
			CMD_DIV: begin
				xr = prr_sm; yr = pii_sm;
				xi = pir_sm; yi = '{neg: ~pri_sm.neg, mag: pri_sm.mag};
			end
			CMD_CONJ: begin
				xr = ar_sm;
				xi = '{neg: ~ai_sm.neg, mag: ai_sm.mag};
			end
			CMD_NEG: begin
				xr = '{neg: ~ar_sm.neg, mag: ar_sm.mag};
				xi = '{neg: ~ai_sm.neg, mag: ai_sm.mag};
			end
			CMD_ABS2, CMD_ABS: begin
				xr = zero_sm;
			end
			default: begin
				xr = zero_sm;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prep_s3.cmd <= cmd_s2;
			prep_s3.re  <= sm_add(xr, yr);
			prep_s3.im  <= sm_add(xi, yi);
			prep_s3.den <= den;
		end
	end

	assign vld_o  = vld_s3;
	assign prep_o = prep_s3;

endmodule

[rtl/cau_iter.sv]
// Pipelined restoring divider (both parts) and square root, one quotient or root bit per stage.
// One setup stage then QW step stages; depends on cau_pkg.
`timescale 1ns / 1ps

module cau_iter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           vld_i,
	input  cau_pkg::prep_t prep_i,
	output logic           vld_o,
	output cau_pkg::iter_t iter_o
);
	import cau_pkg::*;

	logic  vld_s [0:QW];
	iter_t itr_s [0:QW];
	iter_t init;

	// setup: divide-by-zero flag, quotient overflow test, the top dividend bits as first remainder, and the root radicand
	always_comb begin
		init.cmd     = prep_i.cmd;
		init.re      = prep_i.re;
		init.im      = prep_i.im;
		init.den     = prep_i.den;
		init.dz      = (prep_i.den == '0);
		init.ovf_re  = {{OVS{1'b0}}, prep_i.re.mag} >= {prep_i.den, {OVS{1'b0}}};
		init.ovf_im  = {{OVS{1'b0}}, prep_i.im.mag} >= {prep_i.den, {OVS{1'b0}}};
		init.q_re    = '0;
		init.q_im    = '0;
		init.r_re    = prep_i.re.mag >> OVS;
		init.r_im    = prep_i.im.mag >> OVS;
		init.sq_rem  = prep_i.den;
		init.sq_root = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			itr_s[0] <= init;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int  I     = QW - 1 - k;
		localparam bit  XB_ON = (I >= F);
		localparam int  XSH   = (I >= F) ? I - F : 0;
		localparam bit  SQ_ON = (k < W);
		localparam int  J     = (k < W) ? W - 1 - k : 0;

		iter_t           nxt;
		logic [PW-1:0]   sh_re, sh_im, rs_re, rs_im;
		logic [PW:0]     sq_t;

		always_comb begin
			nxt   = itr_s[k];
			sh_re = itr_s[k].re.mag >> XSH;
			sh_im = itr_s[k].im.mag >> XSH;
			rs_re = {itr_s[k].r_re[PW-2:0], XB_ON & sh_re[0]};
			rs_im = {itr_s[k].r_im[PW-2:0], XB_ON & sh_im[0]};
			sq_t  = ({{(PW + 1 - W){1'b0}}, itr_s[k].sq_root} << (J + 1)) |
				((PW + 1)'(1) << (2 * J));

			if (rs_re >= itr_s[k].den) begin
				nxt.r_re = rs_re - itr_s[k].den;
				nxt.q_re = {itr_s[k].q_re[QW-2:0], 1'b1};
			end else begin
				nxt.r_re = rs_re;
				nxt.q_re = {itr_s[k].q_re[QW-2:0], 1'b0};
			end
			if (rs_im >= itr_s[k].den) begin
				nxt.r_im = rs_im - itr_s[k].den;
				nxt.q_im = {itr_s[k].q_im[QW-2:0], 1'b1};
			end else begin
				nxt.r_im = rs_im;
				nxt.q_im = {itr_s[k].q_im[QW-2:0], 1'b0};
			end

			// try setting root bit J: (root + 2^J)^2 - root^2 = root*2^(J+1) + 2^(2J)
			if (SQ_ON && ({1'b0, itr_s[k].sq_rem} >= sq_t)) begin
				nxt.sq_rem  = itr_s[k].sq_rem - sq_t[PW-1:0];
				nxt.sq_root = itr_s[k].sq_root | (W'(1) << J);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				itr_s[k+1] <= nxt;
			end
		end
	end

	assign vld_o  = vld_s[QW];
	assign iter_o = itr_s[QW];

endmodule

[rtl/cau_post.sv]
// Back end: final rounding per operation, saturation, status, and the output register.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_post (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         vld_i,
	input  cau_pkg::iter_t               iter_i,
	output logic                         out_valid,
	output logic signed [cau_pkg::W-1:0] res_re,
	output logic signed [cau_pkg::W-1:0] res_im,
	output logic [1:0]                   status
);
	import cau_pkg::*;

	logic          out_valid_q;
	logic [W-1:0]  res_re_q, res_im_q;
	logic [1:0]    status_q;

	sm_t           fre, fim;
	sat_t          sre, sim;
	logic          up_re, up_im, up_rt;
	logic [1:0]    st;

	always_comb begin
		up_re = {iter_i.r_re, 1'b0} >= {1'b0, iter_i.den};
		up_im = {iter_i.r_im, 1'b0} >= {1'b0, iter_i.den};
		up_rt = iter_i.sq_rem > PW'(iter_i.sq_root);
		fre   = iter_i.re;
		fim   = iter_i.im;
		unique case (iter_i.cmd)
			CMD_ADD, CMD_SUB, CMD_CONJ, CMD_NEG: begin
				fre = iter_i.re;
				fim = iter_i.im;
			end
			CMD_MUL: begin
				fre.mag = rnd(iter_i.re.mag);
				fim.mag = rnd(iter_i.im.mag);
			end
			CMD_DIV: begin
				// an overflowed quotient is forced to full scale so it saturates
				fre.mag = iter_i.ovf_re ? '1 : PW'(iter_i.q_re) + PW'(up_re);
				fim.mag = iter_i.ovf_im ? '1 : PW'(iter_i.q_im) + PW'(up_im);
				if (iter_i.dz) begin
					fre = '{neg: 1'b0, mag: '0};
					fim = '{neg: 1'b0, mag: '0};
				end
			end
			CMD_ABS2: begin
				fre = '{neg: 1'b0, mag: rnd(iter_i.den)};
				fim = '{neg: 1'b0, mag: '0};
			end
			CMD_ABS: begin
				fre = '{neg: 1'b0, mag: PW'(iter_i.sq_root) + PW'(up_rt)};
				fim = '{neg: 1'b0, mag: '0};
			end
			default: begin
				fre = iter_i.re;
			end
		endcase
		sre = sm_sat(fre);
		sim = sm_sat(fim);
		if (iter_i.cmd == CMD_DIV && iter_i.dz) begin
			st = ST_DIVZ;
		end else if (sre.sat || sim.sat) begin
			st = ST_SAT;
		end else begin
			st = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_re_q <= sre.val;
			res_im_q <= sim.val;
			status_q <= st;
		end
	end

	assign out_valid = out_valid_q;
	assign res_re    = res_re_q;
	assign res_im    = res_im_q;
	assign status    = status_q;

endmodule

[dv/tb.sv]
// Testbench for the complex arithmetic unit: drives operation transactions with random gaps
// and output stalls, predicts each result in sign-magnitude arithmetic and checks in order.
// Depends on cau_pkg and complex_arithmetic_unit_top.
`timescale 1ns / 1ps

module tb;
	import cau_pkg::*;

	typedef struct {
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic [1:0]         st;
	} cres_t;

	typedef struct {
		bit          neg;
		logic [63:0] mag;
	} smv_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] cmd = '0;
	logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] res_re, res_im;
	logic [1:0] status;

	cres_t pending_q[$];
	int errors = 0;
	int cycles = 0;
	int idle_pct = 29;

	complex_arithmetic_unit_top u_top (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic smv_t to_sm(logic [31:0] x);
		smv_t v;
		v.neg = x[31];
		v.mag = x[31] ? {32'b0, -x} : {32'b0, x};
		return v;
	endfunction

	function automatic smv_t sm_sum(smv_t a, smv_t b);
		smv_t v;
		if (a.neg == b.neg) begin
			v.neg = a.neg; v.mag = a.mag + b.mag;
		end else if (a.mag >= b.mag) begin
			v.neg = a.neg; v.mag = a.mag - b.mag;
		end else begin
			v.neg = b.neg; v.mag = b.mag - a.mag;
		end
		return v;
	endfunction

	function automatic smv_t sm_prod(smv_t a, smv_t b);
		smv_t v;
		v.neg = a.neg ^ b.neg;
		v.mag = a.mag * b.mag;
		return v;
	endfunction

	function automatic logic [31:0] clamp(smv_t a, inout bit sat);
		if (a.mag == 0) return '0;
		if (a.neg) begin
			if (a.mag > 64'h8000_0000) begin
				sat = 1; return 32'h8000_0000;
			end
			return -a.mag[31:0];
		end
		if (a.mag > 64'h7fff_ffff) begin
			sat = 1; return 32'h7fff_ffff;
		end
		return a.mag[31:0];
	endfunction

	// round(n * 2^16 / d), ties away from zero, wide enough to be exact
	function automatic logic [63:0] quot_round(logic [63:0] n, logic [63:0] d);
		logic [127:0] num, q, r;
		num = {64'b0, n} << 16;
		q = num / d;
		r = num % d;
		if (r >= d - r) q++;
		if (q > 128'h1_0000_0001) q = 128'h1_0000_0001;
		return q[63:0];
	endfunction

	function automatic logic [63:0] root_round(logic [63:0] n);
		logic [63:0] res, rem;
		res = 0; rem = 0;
		for (int i = 31; i >= 0; i--) begin
			logic [63:0] t;
			t = res | (64'd1 << i);
			if (t * t <= n) res = t;
		end
		rem = n - res * res;
		if (rem > res) res++;
		return res;
	endfunction

	function automatic cres_t predict_cau(cmd_t op, logic [31:0] xr, logic [31:0] xi,
			logic [31:0] yr, logic [31:0] yi);
		smv_t ar, ai, br, bi, rr, ri;
		logic [63:0] den;
		bit sat;
		cres_t e;
		ar = to_sm(xr); ai = to_sm(xi); br = to_sm(yr); bi = to_sm(yi);
		sat = 0;
		e.st = ST_OK;
		case (op)
			CMD_ADD: begin
				rr = sm_sum(ar, br); ri = sm_sum(ai, bi);
			end
			CMD_SUB: begin
				br.neg = !br.neg; bi.neg = !bi.neg;
				rr = sm_sum(ar, br); ri = sm_sum(ai, bi);
			end
			CMD_MUL: begin
				smv_t t;
				t = sm_prod(ai, bi); t.neg = !t.neg;
				rr = sm_sum(sm_prod(ar, br), t);
				ri = sm_sum(sm_prod(ar, bi), sm_prod(ai, br));
				rr.mag = (rr.mag + 64'h8000) >> 16;
				ri.mag = (ri.mag + 64'h8000) >> 16;
			end
			CMD_DIV: begin
				smv_t t;
				den = br.mag * br.mag + bi.mag * bi.mag;
				if (den == 0) begin
					rr = '{0, 0}; ri = '{0, 0}; e.st = ST_DIVZ;
				end else begin
					t = sm_prod(ar, bi); t.neg = !t.neg;
					rr = sm_sum(sm_prod(ar, br), sm_prod(ai, bi));
					ri = sm_sum(sm_prod(ai, br), t);
					rr.mag = quot_round(rr.mag, den);
					ri.mag = quot_round(ri.mag, den);
				end
			end
			CMD_CONJ: begin
				rr = ar; ri = ai; ri.neg = !ri.neg;
			end
			CMD_NEG: begin
				rr = ar; ri = ai; rr.neg = !rr.neg; ri.neg = !ri.neg;
			end
			CMD_ABS2: begin
				rr = '{0, (ar.mag * ar.mag + ai.mag * ai.mag + 64'h8000) >> 16};
				ri = '{0, 0};
			end
			default: begin
				rr = '{0, root_round(ar.mag * ar.mag + ai.mag * ai.mag)};
				ri = '{0, 0};
			end
		endcase
		e.re = clamp(rr, sat);
		e.im = clamp(ri, sat);
		if (e.st == ST_OK && sat) e.st = ST_SAT;
		return e;
	endfunction

	// leaves in_valid high on return; drain() drops it, and the next call drops it only for an idle gap
	task automatic send_op(cmd_t op, logic [31:0] xr, logic [31:0] xi,
			logic [31:0] yr, logic [31:0] yi);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op; a_re <= xr; a_im <= xi; b_re <= yr; b_im <= yi;
		pending_q.push_back(predict_cau(op, xr, xi, yr, yi));
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_stall <= (idle_pct > 0) && ($urandom_range(99) < idle_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result re=%h im=%h st=%0d", $time,
					res_re, res_im, status);
				errors++;
			end else begin
				cres_t e;
				e = pending_q.pop_front();
				if (res_re !== e.re || res_im !== e.im || status !== e.st) begin
					$display("%0t: mismatch expected re=%h im=%h st=%0d actual re=%h im=%h st=%0d",
						$time, e.re, e.im, e.st, res_re, res_im, status);
					errors++;
				end
			end
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h8000_0000 + $urandom_range(3);
			1: return 32'h7fff_ffff - $urandom_range(3);
			2: return $urandom_range(32'h3ffff) - 32'h1ffff;
			3: return 0;
			default: return $urandom;
		endcase
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
	endtask

	task automatic test_extremes();
		logic [31:0] ext[5] = '{32'h8000_0000, 32'h7fff_ffff, 0, 32'h0001_0000, 32'hffff_ffff};
		for (int c = 0; c < 8; c++)
			for (int k = 0; k < 3; k++)
				send_op(cmd_t'(c), ext[k], ext[(k + 1) % 5], ext[(k + 2) % 5], ext[(k + 4) % 5]);
		send_op(CMD_DIV, 32'h0001_0000, 32'h0002_0000, 0, 0);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++)
			send_op(cmd_t'($urandom_range(7)), rand_word(), rand_word(), rand_word(), rand_word());
	endtask

	task automatic test_back_to_back(int n);
		idle_pct = 0;
		test_random(n);
		drain();
		idle_pct = 29;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_extremes();
		drain();
		test_random(500);
		test_back_to_back(200);
		test_random(400);
		drain();
		repeat (60) @(negedge clk);
		if (errors == 0 && pending_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

[files.f]
rtl/cau_pkg.sv
rtl/cau_prep.sv
rtl/cau_iter.sv
rtl/cau_post.sv
rtl/complex_arithmetic_unit_top.sv
dv/tb.sv
